// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL; included by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AFWP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define AFWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/afwp_pkg.sv =====
package afwp_pkg;

  localparam int unsigned WordW  = 24;
  localparam int unsigned ValueW = 32;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ECG_EN      = 3'd0;
  localparam logic [2:0] REG_TIM_EN      = 3'd1;
  localparam logic [2:0] REG_PPG_TAG_MAX = 3'd2;
  localparam logic [2:0] REG_ECG_TAG     = 3'd3;
  localparam logic [2:0] REG_LOFF_TAG    = 3'd4;
  localparam logic [2:0] REG_TIM_TAG     = 3'd5;
  localparam logic [2:0] REG_PPG_FRAME   = 3'd6;

  // Reset values
  localparam logic       RST_ECG_EN      = 1'b1;
  localparam logic       RST_TIM_EN      = 1'b1;
  localparam logic [3:0] RST_PPG_TAG_MAX = 4'd8;
  localparam logic [3:0] RST_ECG_TAG     = 4'd12;
  localparam logic [3:0] RST_LOFF_TAG    = 4'd13;
  localparam logic [3:0] RST_TIM_TAG     = 4'd14;
  localparam logic [7:0] RST_PPG_FRAME   = 8'd6;

  typedef enum logic [2:0] {
    KIND_PPG      = 3'd0,
    KIND_ECG_FR   = 3'd1,
    KIND_ECG_VAL  = 3'd2,
    KIND_LOFF_CH0 = 3'd3,
    KIND_LOFF_CH1 = 3'd4,
    KIND_TIM_IDX  = 3'd5,
    KIND_TIM_DATA = 3'd6
  } afwp_kind_t;

  typedef struct packed {
    logic       ecg_en;
    logic       tim_en;
    logic [3:0] ppg_tag_max;
    logic [3:0] ecg_tag;
    logic [3:0] loff_tag;
    logic [3:0] tim_tag;
    logic [7:0] ppg_frame;
  } afwp_cfg_t;

  typedef struct packed {
    afwp_kind_t          kind;
    logic [ValueW-1:0]   value;
  } afwp_res_t;

  typedef struct packed {
    logic [1:0] cnt;        // results caused by the word: 0, 1 or 2
    afwp_res_t  res0;
    afwp_res_t  res1;
    logic       is_ppg;     // accepted PPG word
    logic       is_ecg;
    logic       is_tim;
    logic [7:0] frame_nxt;  // frame count after a PPG word
    logic       frame_end;
  } afwp_dec_t;

endpackage

// ===== design/afwp_cfg_regs.sv =====
module afwp_cfg_regs
  import afwp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output afwp_cfg_t        cfg
);

  afwp_cfg_t  cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[AddrW-1:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ecg_en      <= RST_ECG_EN;
      cfg_r.tim_en      <= RST_TIM_EN;
      cfg_r.ppg_tag_max <= RST_PPG_TAG_MAX;
      cfg_r.ecg_tag     <= RST_ECG_TAG;
      cfg_r.loff_tag    <= RST_LOFF_TAG;
      cfg_r.tim_tag     <= RST_TIM_TAG;
      cfg_r.ppg_frame   <= RST_PPG_FRAME;
    end else if (wr_en) begin
      case (idx)
        REG_ECG_EN:      cfg_r.ecg_en      <= pwdata[0];
        REG_TIM_EN:      cfg_r.tim_en      <= pwdata[0];
        REG_PPG_TAG_MAX: cfg_r.ppg_tag_max <= pwdata[3:0];
        REG_ECG_TAG:     cfg_r.ecg_tag     <= pwdata[3:0];
        REG_LOFF_TAG:    cfg_r.loff_tag    <= pwdata[3:0];
        REG_TIM_TAG:     cfg_r.tim_tag     <= pwdata[3:0];
        REG_PPG_FRAME:   cfg_r.ppg_frame   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_ECG_EN:      prdata[0]   = cfg_r.ecg_en;
      REG_TIM_EN:      prdata[0]   = cfg_r.tim_en;
      REG_PPG_TAG_MAX: prdata[3:0] = cfg_r.ppg_tag_max;
      REG_ECG_TAG:     prdata[3:0] = cfg_r.ecg_tag;
      REG_LOFF_TAG:    prdata[3:0] = cfg_r.loff_tag;
      REG_TIM_TAG:     prdata[3:0] = cfg_r.tim_tag;
      REG_PPG_FRAME:   prdata[7:0] = cfg_r.ppg_frame;
      default:         prdata      = '0;
    endcase
  end

endmodule

// ===== design/afwp_decode.sv =====
module afwp_decode
  import afwp_pkg::*;
(
  input  logic [WordW-1:0]  word,
  input  afwp_cfg_t         cfg,
  input  logic              seen,
  input  logic [ValueW-1:0] ecg_ctr,
  input  logic [7:0]        frame_cnt,
  output afwp_dec_t         dec
);

  logic [3:0] tag;
  logic       gate;
  logic       ppg_ok;
  logic [7:0] frame_inc;

  assign tag       = word[23:20];
  assign gate      = cfg.ecg_en && cfg.tim_en;
  assign ppg_ok    = (tag <= cfg.ppg_tag_max) && (!gate || seen);
  assign frame_inc = frame_cnt + 8'd1;

  always_comb begin
    dec            = '0;
    dec.res0.kind  = KIND_PPG;
    dec.res1.kind  = KIND_PPG;
    dec.frame_end  = (frame_inc == cfg.ppg_frame);
    dec.frame_nxt  = dec.frame_end ? 8'd0 : frame_inc;
    if (ppg_ok) begin
      dec.cnt         = 2'd1;
      dec.is_ppg      = 1'b1;
      dec.res0.kind   = KIND_PPG;
      dec.res0.value  = {{(ValueW-20){word[19]}}, word[19:0]};
    end else if (tag == cfg.ecg_tag) begin
      dec.cnt         = 2'd2;
      dec.is_ecg      = 1'b1;
      dec.res0.kind   = KIND_ECG_FR;
      dec.res0.value  = {{(ValueW-1){1'b0}}, word[18]};
      dec.res1.kind   = KIND_ECG_VAL;
      dec.res1.value  = {{(ValueW-18){word[17]}}, word[17:0]};
    end else if (tag == cfg.loff_tag) begin
      dec.cnt         = 2'd1;
      dec.res0.kind   = word[18] ? KIND_LOFF_CH1 : KIND_LOFF_CH0;
      // bit 19 acts as the sign of the 12-bit value
      dec.res0.value  = {{(ValueW-12){word[19]}}, word[11:0]};
    end else if (tag == cfg.tim_tag) begin
      dec.cnt         = 2'd2;
      dec.is_tim      = 1'b1;
      dec.res0.kind   = KIND_TIM_IDX;
      dec.res0.value  = ecg_ctr;
      dec.res1.kind   = KIND_TIM_DATA;
      dec.res1.value  = {{(ValueW-10){1'b0}}, word[9:0]};
    end
  end

endmodule

// ===== design/afe_fifo_word_parser_unit.sv =====
// Sensor FIFO word decoder.
// Input channel: in_valid / in_stall / in_fifo_word carry one 24-bit FIFO
// word per item, tag in bits 23..20. Result channel: out_valid / out_stall
// with out_kind, out_value and out_last; out_last marks the final result
// of a word. Tag codes, enables and frame length sit in an APB register
// file (psel/penable/pwrite/paddr/pwdata/prdata/pready, pready tied high),
// which the user must write only while the block is idle; the block does
// not enforce this. A word goes through the word register, then the result
// register. ECG and timing words give two results, PPG and lead-off words
// one; the single result register takes one result per cycle unless the
// receiver stalls. Gated-out and unknown words produce nothing.
// Reset (synchronous, rst_n low) loads the register defaults, sets the ECG
// sample counter to all ones and clears the timing-seen flag, the frame
// count and both valid registers.
// When the receiver stalls, the result register holds; the word register
// then holds too and in_stall rises, but one new word is still taken while
// a result waits.
`include "assert_macros.svh"

module afe_fifo_word_parser_unit
  import afwp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [WordW-1:0]         in_fifo_word,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_kind,
  output logic signed [ValueW-1:0] out_value,
  output logic                     out_last,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  afwp_cfg_t         cfg;
  afwp_dec_t         dec;

  // word register
  logic              in_vld_r;
  logic [WordW-1:0]  in_word_r;
  // result register
  logic              out_vld_r;
  afwp_res_t         out_res_r;
  logic              out_last_r;
  // decode state
  logic [ValueW-1:0] ecg_ctr_r;
  logic              seen_r;
  logic [7:0]        frame_cnt_r;
  logic              phase_r;     // second result of the held word is next

  logic              push_ok;
  logic              push;
  logic              consume;
  logic              in_take;
  afwp_res_t         res_sel;
  logic              last_sel;

  assign pready = 1'b1;

  afwp_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  afwp_decode u_dec (
    .word      (in_word_r),
    .cfg       (cfg),
    .seen      (seen_r),
    .ecg_ctr   (ecg_ctr_r),
    .frame_cnt (frame_cnt_r),
    .dec       (dec)
  );

  // Advance a result into the output register when it is free or draining.
  assign push_ok  = !out_vld_r || !out_stall;
  assign push     = in_vld_r && (dec.cnt != 2'd0) && push_ok;
  // Drop a word with no result at once; otherwise retire it with its last push.
  assign consume  = in_vld_r &&
                    ((dec.cnt == 2'd0) || (push && (phase_r || dec.cnt == 2'd1)));
  assign in_stall = in_vld_r && !consume;
  assign in_take  = in_valid && !in_stall;

  assign res_sel  = phase_r ? dec.res1 : dec.res0;
  assign last_sel = phase_r || (dec.cnt == 2'd1);

  // word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_fifo_word;
    end
  end

  // phase of a two-result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (consume) begin
      phase_r <= 1'b0;
    end else if (push) begin
      phase_r <= 1'b1;
    end
  end

  // Update decode state only when the word retires, so both of its
  // results see the state left by the word before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecg_ctr_r   <= '1;
      seen_r      <= 1'b0;
      frame_cnt_r <= 8'd0;
    end else if (consume) begin
      if (dec.is_ppg) begin
        frame_cnt_r <= dec.frame_nxt;
        if (dec.frame_end) begin
          seen_r <= 1'b0;
        end
      end
      if (dec.is_ecg) begin
        ecg_ctr_r <= ecg_ctr_r + {{(ValueW-1){1'b0}}, 1'b1};
      end
      if (dec.is_tim) begin
        seen_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r  <= res_sel;
      out_last_r <= last_sel;
    end
  end

  assign out_valid = out_vld_r;
  assign out_kind  = out_res_r.kind;
  assign out_value = out_res_r.value;
  assign out_last  = out_last_r;

  `AFWP_ASSERT_NOW(a_phase_held, clk, rst_n, phase_r, in_vld_r && (dec.cnt == 2'd2))
  `AFWP_ASSERT_NOW(a_fr_not_last, clk, rst_n,
    out_vld_r && (out_res_r.kind == KIND_ECG_FR || out_res_r.kind == KIND_TIM_IDX),
    !out_last_r)
  `AFWP_ASSERT_NEXT(a_timing_sets_seen, clk, rst_n, consume && dec.is_tim, seen_r)
  `AFWP_ASSERT_NEXT(a_two_result_phase, clk, rst_n,
    push && !phase_r && (dec.cnt == 2'd2), phase_r && in_vld_r)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the sensor FIFO word decoder.
module tb_top;
  import afwp_pkg::*;

  localparam int NUM_PHASES = 10;
  localparam int SETTLE_CYC = 4;

  // One expected result: what the decoder must emit, oldest first.
  typedef struct {
    afwp_kind_t        kind;
    logic [ValueW-1:0] value;
    logic              last;
  } decoded_res_t;

  // Directed row: the word, and where the answer is obvious, the answer itself.
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic              typed;
    logic [1:0]        n;
    afwp_kind_t        k0;
    logic [ValueW-1:0] v0;
    afwp_kind_t        k1;
    logic [ValueW-1:0] v1;
  } word_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [WordW-1:0]         in_fifo_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               out_kind;
  logic signed [ValueW-1:0] out_value;
  logic                     out_last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [AddrW-1:0]         paddr = '0;
  logic [DataW-1:0]         pwdata = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  // Shadow of the register file and of the decoder's own state.
  afwp_cfg_t         reg_shadow;
  logic [ValueW-1:0] ecg_index;
  logic              timing_seen_q;
  logic [7:0]        frame_cnt;

  decoded_res_t pending_results[$];
  int           mismatch_cnt = 0;
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;

  afe_fifo_word_parser_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_fifo_word(in_fifo_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .out_last    (out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs; the normal run is far shorter.
  initial begin
    #(64'd12_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic void expect_result(input afwp_kind_t kind, input logic [ValueW-1:0] value,
                                        input logic last);
    decoded_res_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    pending_results.push_back(r);
  endfunction

  // Decode one accepted word: advance the shadow state and, if keep is set,
  // queue the results it causes. Return how many results the word causes.
  function automatic int decode_word(input logic [WordW-1:0] w, input bit keep);
    logic [3:0] tag;
    logic       gate_on;
    tag     = w[23:20];
    gate_on = reg_shadow.ecg_en && reg_shadow.tim_en;
    // PPG wins first, but only when the timing gate lets it through
    if (tag <= reg_shadow.ppg_tag_max && (!gate_on || timing_seen_q)) begin
      frame_cnt = frame_cnt + 8'd1;
      if (frame_cnt == reg_shadow.ppg_frame) begin
        frame_cnt     = '0;
        timing_seen_q = 1'b0;
      end
      if (keep) expect_result(KIND_PPG, {{12{w[19]}}, w[19:0]}, 1'b1);
      return 1;
    end
    if (tag == reg_shadow.ecg_tag) begin
      ecg_index = ecg_index + 1;
      if (keep) begin
        expect_result(KIND_ECG_FR, {31'd0, w[18]}, 1'b0);
        expect_result(KIND_ECG_VAL, {{14{w[17]}}, w[17:0]}, 1'b1);
      end
      return 1 + 1;
    end
    if (tag == reg_shadow.loff_tag) begin
      // bit 19 is the sign, bit 18 picks the channel
      if (keep) expect_result(w[18] ? KIND_LOFF_CH1 : KIND_LOFF_CH0,
                              {{20{w[19]}}, w[11:0]}, 1'b1);
      return 1;
    end
    if (tag == reg_shadow.tim_tag) begin
      timing_seen_q = 1'b1;
      if (keep) begin
        expect_result(KIND_TIM_IDX, ecg_index, 1'b0);
        expect_result(KIND_TIM_DATA, {22'd0, w[9:0]}, 1'b1);
      end
      return 1 + 1;
    end
    return 0;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  // Mostly well-formed traffic for the current tag map, plus some noise.
  function automatic logic [WordW-1:0] make_word();
    int         pick;
    logic [3:0] tag;
    logic [19:0] body;
    body = 20'($urandom);
    if ($urandom_range(0, 19) == 0) body = $urandom_range(0, 1) ? '1 : '0;
    pick = $urandom_range(0, 99);
    if (pick < 14)      tag = reg_shadow.tim_tag;
    else if (pick < 52) tag = 4'($urandom_range(0, reg_shadow.ppg_tag_max));
    else if (pick < 70) tag = reg_shadow.ecg_tag;
    else if (pick < 82) tag = reg_shadow.loff_tag;
    else                tag = 4'($urandom_range(0, 15));
    return {tag, body};
  endfunction

  // Offer one word after a random gap; return once it has been taken.
  // Called right after a rising edge; holds the word steady while stalled.
  task automatic push_word(input logic [WordW-1:0] w, input bit keep, output int n);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_fifo_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = decode_word(w, keep);
  endtask

  // Drop valid, wait for every queued result, then let the pipe empty out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write every register through the APB port: setup cycle, then access cycle.
  task automatic program_regs(input afwp_cfg_t c);
    logic [DataW-1:0] data;
    logic [2:0]       idx;
    for (int i = int'(REG_ECG_EN); i <= int'(REG_PPG_FRAME); i++) begin
      idx = 3'(i);
      case (idx)
        REG_ECG_EN:      data = {31'd0, c.ecg_en};
        REG_TIM_EN:      data = {31'd0, c.tim_en};
        REG_PPG_TAG_MAX: data = {28'd0, c.ppg_tag_max};
        REG_ECG_TAG:     data = {28'd0, c.ecg_tag};
        REG_LOFF_TAG:    data = {28'd0, c.loff_tag};
        REG_TIM_TAG:     data = {28'd0, c.tim_tag};
        default:         data = {24'd0, c.ppg_frame};
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_shadow = c;
  endtask

  // Result side: check each taken result against the oldest expectation,
  // then hold off the next one for a random number of cycles.
  always @(posedge clk) begin : result_side
    decoded_res_t exp_r;
    int           hold;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d value %h last %0d",
                 out_kind, out_value, out_last);
          mismatch_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, out_kind);
            mismatch_cnt++;
          end
          if (out_value !== exp_r.value) begin
            $error("value: expected %h, got %h", exp_r.value, out_value);
            mismatch_cnt++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_last);
            mismatch_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        hold = draw_wait(recv_calm);
        out_stall <= (hold != 0);
      end else if (hold != 0) begin
        // release the stall on the last held cycle
        hold = hold - 1;
        if (hold == 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    word_row_t  dir_tbl [23];
    afwp_cfg_t  phase_cfg [NUM_PHASES];
    int         phase_len [NUM_PHASES];
    int         n;
    int         done;
    int         raw;

    // Directed rows run on the reset register values: gate on, PPG tags
    // 0..8, ECG 12, lead-off 13, timing 14, six PPG words per frame.
    dir_tbl = '{
      // PPG before any timing word: gated out, and tag 0 matches nothing else
      '{24'h012345, 1'b1, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      // unknown tag, all ones and all zeros in the body
      '{24'hFFFFFF, 1'b1, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      '{24'hF00000, 1'b1, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      // timing word before any ECG sample: index is still all ones
      '{24'hE003FF, 1'b1, 2'd2, KIND_TIM_IDX, 32'hFFFFFFFF, KIND_TIM_DATA, 32'h3FF},
      // PPG extremes, now let through
      '{24'h07FFFF, 1'b1, 2'd1, KIND_PPG, 32'h0007FFFF, KIND_PPG, 32'h0},
      '{24'h880000, 1'b1, 2'd1, KIND_PPG, 32'hFFF80000, KIND_PPG, 32'h0},
      '{24'h8FFFFF, 1'b1, 2'd1, KIND_PPG, 32'hFFFFFFFF, KIND_PPG, 32'h0},
      '{24'h000000, 1'b1, 2'd1, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      // ECG extremes
      '{24'hC5FFFF, 1'b1, 2'd2, KIND_ECG_FR, 32'h1, KIND_ECG_VAL, 32'h0001FFFF},
      '{24'hC20000, 1'b1, 2'd2, KIND_ECG_FR, 32'h0, KIND_ECG_VAL, 32'hFFFE0000},
      // lead-off on both channels, both signs
      '{24'hD807FF, 1'b1, 2'd1, KIND_LOFF_CH0, 32'hFFFFF7FF, KIND_PPG, 32'h0},
      '{24'hD40FFF, 1'b1, 2'd1, KIND_LOFF_CH1, 32'h00000FFF, KIND_PPG, 32'h0},
      '{24'hDC0000, 1'b1, 2'd1, KIND_LOFF_CH1, 32'hFFFFF000, KIND_PPG, 32'h0},
      // timing after two ECG samples
      '{24'hE00000, 1'b1, 2'd2, KIND_TIM_IDX, 32'h1, KIND_TIM_DATA, 32'h0},
      // fifth and sixth PPG of the frame; the sixth ends it and clears the gate
      '{24'h100001, 1'b1, 2'd1, KIND_PPG, 32'h1, KIND_PPG, 32'h0},
      '{24'h2FFFFF, 1'b1, 2'd1, KIND_PPG, 32'hFFFFFFFF, KIND_PPG, 32'h0},
      // gated again after the frame end
      '{24'h300005, 1'b1, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      // tags just above the PPG range with no code assigned
      '{24'h9ABCDE, 1'b1, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      '{24'hAFFFFF, 1'b1, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      // the rest go through the predictor
      '{24'hE7FC00, 1'b0, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      '{24'h456789, 1'b0, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      '{24'hCBCDEF, 1'b0, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0},
      '{24'hD5A5A5, 1'b0, 2'd0, KIND_PPG, 32'h0, KIND_PPG, 32'h0}
    };

    // Settings per phase: defaults, gate off either way, all minimum (all
    // tags overlap), all maximum, a 256-word frame, timing tag in the PPG
    // range, a 255-word frame, one-word frames, and a random one.
    phase_cfg[0] = '{1'b1, 1'b1, 4'd8,  4'd12, 4'd13, 4'd14, 8'd6};
    phase_cfg[1] = '{1'b0, 1'b1, 4'd7,  4'd8,  4'd9,  4'd10, 8'd3};
    phase_cfg[2] = '{1'b1, 1'b0, 4'd5,  4'd11, 4'd6,  4'd15, 8'd1};
    phase_cfg[3] = '{1'b0, 1'b0, 4'd0,  4'd0,  4'd0,  4'd0,  8'd0};
    phase_cfg[4] = '{1'b1, 1'b1, 4'd15, 4'd15, 4'd15, 4'd15, 8'd255};
    phase_cfg[5] = '{1'b1, 1'b1, 4'd3,  4'd4,  4'd4,  4'd5,  8'd0};
    phase_cfg[6] = '{1'b1, 1'b1, 4'd9,  4'd2,  4'd14, 4'd3,  8'd2};
    phase_cfg[7] = '{1'b1, 1'b1, 4'd8,  4'd12, 4'd13, 4'd14, 8'd255};
    phase_cfg[8] = '{1'b1, 1'b1, 4'd1,  4'd10, 4'd11, 4'd12, 8'd1};
    phase_cfg[9].ecg_en      = 1'($urandom_range(0, 1));
    phase_cfg[9].tim_en      = 1'($urandom_range(0, 1));
    phase_cfg[9].ppg_tag_max = 4'($urandom_range(0, 15));
    phase_cfg[9].ecg_tag     = 4'($urandom_range(0, 15));
    phase_cfg[9].loff_tag    = 4'($urandom_range(0, 15));
    phase_cfg[9].tim_tag     = 4'($urandom_range(0, 15));
    phase_cfg[9].ppg_frame   = 8'($urandom_range(0, 255));
    // the 256-word frame phase runs long enough to wrap the frame count
    phase_len = '{80, 80, 80, 60, 80, 660, 80, 80, 80, 80};

    // Reset values of the register file and the decoder state.
    reg_shadow    = '{RST_ECG_EN, RST_TIM_EN, RST_PPG_TAG_MAX, RST_ECG_TAG,
                      RST_LOFF_TAG, RST_TIM_TAG, RST_PPG_FRAME};
    ecg_index     = '1;
    timing_seen_q = 1'b0;
    frame_cnt     = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: queue the typed answer where there is one, else
    // advance through the predictor as usual.
    foreach (dir_tbl[i]) begin
      push_word(dir_tbl[i].word, !dir_tbl[i].typed, n);
      if (dir_tbl[i].typed && dir_tbl[i].n != 2'd0)
        expect_result(dir_tbl[i].k0, dir_tbl[i].v0, dir_tbl[i].n == 2'd1);
      if (dir_tbl[i].typed && dir_tbl[i].n == 2'd2)
        expect_result(dir_tbl[i].k1, dir_tbl[i].v1, 1'b1);
    end

    // Random part: reprogram while idle, then stream words until the phase
    // has seen its share of useful words or four times as many in all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      program_regs(phase_cfg[p]);
      done = 0;
      raw  = 0;
      while (done < phase_len[p] && raw < 4 * phase_len[p]) begin
        push_word(make_word(), 1'b1, n);
        raw++;
        if (n != 0) done++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
